FILE: design/mccf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mccf_pkg
// Shared types and constants for the disk pixel generator.
// ----------------------------------------------------------------------------
package mccf_pkg;

   localparam logic [23:0] OUTLINE_COLOUR = 24'h000064;
   localparam int PIX_BITS = 18;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_NEXT  = 1'b1;

   // divider request: 40-bit signed numerator, 19-bit positive divisor
   localparam int NUM_BITS = 40;
   localparam int DEN_BITS = 19;

   typedef struct packed {
      logic                        start;
      logic signed [NUM_BITS-1:0]  num;
      logic [DEN_BITS-1:0]         den;
   } div_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [PIX_BITS-1:0]  quot;
   } div_rsp_type;

   function automatic logic [23:0] pair_colour(input logic [1:0] idx);
      logic [23:0] c;
      case (idx)
         2'd0:    c = 24'h800080;
         2'd1:    c = 24'hE16941;
         2'd2:    c = 24'h0000FF;
         default: c = 24'h00FFFF;
      endcase
      return c;
   endfunction

endpackage

FILE: design/mccf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mccf_divider
// Restoring serial divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module mccf_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  mccf_pkg::div_req_type  req,
   output mccf_pkg::div_rsp_type  rsp
);
   import mccf_pkg::*;

   localparam int MAG_BITS = NUM_BITS - 1;
   localparam int CNT_BITS = $clog2(MAG_BITS + 1);

   logic [MAG_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   trial;
   logic [MAG_BITS-1:0] qmag;

   assign trial = {rem_ff[DEN_BITS-1:0], quo_ff[MAG_BITS-1]};
   assign qmag  = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   // shift one numerator bit into the remainder a cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         neg_in = req.num[NUM_BITS-1];
         quo_in = req.num[NUM_BITS-1] ? MAG_BITS'(-req.num) : MAG_BITS'(req.num);
         rem_in = '0;
         den_in = req.den;
         cnt_in = CNT_BITS'(MAG_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[MAG_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[MAG_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = PIX_BITS'(qmag);

   // check the sequencing
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("divider done while running");
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      req.start |=> run_ff) else $error("divider did not start");
   a_no_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff)) else $error("divider done without run");

endmodule

FILE: design/midpoint_circle_chord_fill_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_chord_fill_core
// Disk pixel generator: midpoint circle outline and DDA diameter fill.
// ----------------------------------------------------------------------------
// Usage: send a start word (req_tuser 0) with centre and radius on req_; it
// returns one word with rsp_tuser (pixel_valid) low. Each next word
// (req_tuser 1) returns one pixel on rsp_, in walk order; the final pixel
// carries rsp_tlast, and next words after that return an all-zero word.
// Sequencing: start words, outline pixels and line start pixels pass from
// ST_IDLE through ST_CALC to ST_OUT, where rsp_tvalid is high. A line body
// pixel takes a serial quotient from the divider, 39 bits at one bit a
// cycle, and passes from ST_CALC through ST_DIV to ST_OUT.
// One word is in flight at a time: req_tready is low from accept until the
// result word has been taken. A stalled rsp_tready holds the result word.
// Reset (synchronous, active high) returns the block to idle with no circle.
// ----------------------------------------------------------------------------
module midpoint_circle_chord_fill_core #(
   parameter int MAX_RADIUS = 4095,
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // center_x, center_y, radius, 4'b0
   input  logic        req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // pixel_x, pixel_y, pixel_colour, 4'b0
   output logic        rsp_tuser,  // pixel_valid
   output logic        rsp_tlast   // last_pixel
);
   import mccf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   localparam int W = 20;  // working signed width

   // position within one pair
   localparam logic [1:0] PH_OUTLINE_A  = 2'd0;
   localparam logic [1:0] PH_OUTLINE_B  = 2'd1;
   localparam logic [1:0] PH_LINE_START = 2'd2;
   localparam logic [1:0] PH_LINE_BODY  = 2'd3;

   state_type state_ff, state_in;
   logic signed [W-1:0] cx_ff, cy_ff, wx_ff, wy_ff, dec_ff;
   logic [1:0]          pair_ff;
   logic [1:0]          phase_ff;
   logic signed [W-1:0] fx_ff, fy_ff, tomaj_ff, cur_ff, smaj_ff, smin_ff;
   logic                xmaj_ff, busy_ff;
   logic [64:0]         out_ff;
   logic                last_ff;
   logic                act_ff;
   logic [15:0]         inx_ff, iny_ff;
   logic [11:0]         inr_ff;
   div_req_type         dreq;
   div_rsp_type         drsp;

   mccf_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // pair endpoints
   logic signed [W-1:0] pa, pb, ax, ay, bx, by, ddx, ddy, adx, ady;
   logic signed [W-1:0] sax, say, sbx, sby, m0, s0, tt;
   logic                xm, swp, fin;
   logic signed [NUM_BITS-1:0] num;
   always_comb begin
      pa = pair_ff[1] ? wy_ff : wx_ff;
      pb = pair_ff[1] ? wx_ff : wy_ff;
      ax = cx_ff + pa;
      bx = cx_ff - pa;
      ay = pair_ff[0] ? cy_ff - pb : cy_ff + pb;
      by = pair_ff[0] ? cy_ff + pb : cy_ff - pb;
      ddx = bx - ax;
      ddy = by - ay;
      adx = ddx[W-1] ? -ddx : ddx;
      ady = ddy[W-1] ? -ddy : ddy;
      xm  = ady <= adx;
      swp = xm ? (ax > bx) : (ay > by);
      sax = swp ? bx : ax;
      say = swp ? by : ay;
      sbx = swp ? ax : bx;
      sby = swp ? ay : by;
      fin = (pair_ff == 2'd3) && !(wx_ff < wy_ff);
      m0  = xmaj_ff ? fy_ff : fx_ff;
      s0  = xmaj_ff ? fx_ff : fy_ff;
      tt  = cur_ff + W'(1) - s0;
      num = NUM_BITS'(2 * m0 * smaj_ff) + NUM_BITS'(2 * tt * smin_ff)
          + NUM_BITS'(smaj_ff);
   end

   logic [15:0] rsat;
   assign rsat = (32'(inr_ff) > MAX_RADIUS) ? 16'(MAX_RADIUS) : 16'(inr_ff);

   logic [23:0] pcol;
   assign pcol = pair_colour(pair_ff);

   function automatic logic [64:0] pack(input logic signed [W-1:0] x,
                                        input logic signed [W-1:0] y,
                                        input logic [23:0] c);
      return {4'b0, c, y[PIX_BITS-1:0], x[PIX_BITS-1:0], 1'b1};
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = out_ff[64:1];
   assign rsp_tuser  = out_ff[0];
   assign rsp_tlast  = last_ff;
   assign dreq.start = (state_ff == ST_CALC) && act_ff && busy_ff
                       && (phase_ff == PH_LINE_BODY);
   assign dreq.num   = num;
   assign dreq.den   = DEN_BITS'(2 * smaj_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_CALC;
         ST_CALC: state_in = dreq.start ? ST_DIV : ST_OUT;
         ST_DIV:  if (drsp.done) state_in = ST_OUT;
         ST_OUT:  if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer and walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         phase_ff <= PH_OUTLINE_A;
         pair_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && req_tvalid) begin
            act_ff <= req_tuser;
            inx_ff <= req_tdata[15:0];
            iny_ff <= req_tdata[31:16];
            inr_ff <= req_tdata[43:32];
         end
         if (state_ff == ST_CALC) begin
            out_ff  <= '0;
            last_ff <= 1'b0;
            if (act_ff == ACTION_START) begin
               cx_ff    <= W'(inx_ff & 16'((1 << COORD_BITS) - 1));
               cy_ff    <= W'(iny_ff & 16'((1 << COORD_BITS) - 1));
               wx_ff    <= '0;
               wy_ff    <= W'(rsat);
               dec_ff   <= W'(1) - W'(rsat);
               pair_ff  <= 2'd0;
               phase_ff <= PH_OUTLINE_A;
               busy_ff  <= 1'b1;
            end else if (busy_ff) begin
               case (phase_ff)
                  PH_OUTLINE_A: begin
                     out_ff   <= pack(ax, ay, OUTLINE_COLOUR);
                     phase_ff <= PH_OUTLINE_B;
                  end
                  PH_OUTLINE_B: begin
                     out_ff   <= pack(bx, by, OUTLINE_COLOUR);
                     xmaj_ff  <= xm;
                     fx_ff    <= sax;
                     fy_ff    <= say;
                     tomaj_ff <= xm ? sbx : sby;
                     cur_ff   <= xm ? sax : say;
                     smaj_ff  <= xm ? sbx - sax : sby - say;
                     smin_ff  <= xm ? sby - say : sbx - sax;
                     phase_ff <= PH_LINE_START;
                  end
                  PH_LINE_START: begin
                     out_ff <= pack(fx_ff, fy_ff, pcol);
                     if (cur_ff >= tomaj_ff) begin
                        phase_ff <= PH_OUTLINE_A;
                        pair_ff  <= pair_ff + 1'b1;
                        if (pair_ff == 2'd3) begin
                           if (fin) begin
                              busy_ff <= 1'b0;
                              last_ff <= 1'b1;
                           end else begin
                              if (dec_ff <= 0) dec_ff <= W'(dec_ff + 2 * wx_ff + 3);
                              else begin
                                 dec_ff <= W'(dec_ff + 2 * (wx_ff - wy_ff) + 5);
                                 wy_ff  <= wy_ff - W'(1);
                              end
                              wx_ff <= wx_ff + W'(1);
                           end
                        end
                     end else phase_ff <= PH_LINE_BODY;
                  end
                  default: cur_ff <= cur_ff + W'(1);
               endcase
            end
         end
         // body pixel: quotient is ready, finish the pair if at the end
         if (state_ff == ST_DIV && drsp.done) begin
            out_ff <= xmaj_ff ? pack(cur_ff, W'(drsp.quot), pcol)
                              : pack(W'(drsp.quot), cur_ff, pcol);
            if (cur_ff >= tomaj_ff) begin
               phase_ff <= PH_OUTLINE_A;
               pair_ff  <= pair_ff + 1'b1;
               if (pair_ff == 2'd3) begin
                  if (fin) begin
                     busy_ff <= 1'b0;
                     last_ff <= 1'b1;
                  end else begin
                     if (dec_ff <= 0) dec_ff <= W'(dec_ff + 2 * wx_ff + 3);
                     else begin
                        dec_ff <= W'(dec_ff + 2 * (wx_ff - wy_ff) + 5);
                        wy_ff  <= wy_ff - W'(1);
                     end
                     wx_ff <= wx_ff + W'(1);
                  end
               end
            end
         end
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while result pending");
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser) else $error("last without pixel");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !busy_ff) else $error("last while busy");

endmodule
